// ===== sv/psk_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the partitioned stack.
package psk_pkg;

    localparam int MAX_STACKS = 8;
    localparam int MEM_DEPTH  = 256;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W      = $clog2(MAX_STACKS);
    localparam int CNT_W      = 4;
    localparam int TE_W       = 9;
    localparam int PSIZE_W    = $clog2(MEM_DEPTH) + 1;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int PROD_W     = IDX_W + PSIZE_W;
    localparam int DIV_CNT_W  = $clog2(PSIZE_W);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CFG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ENTRIES = 1'b1;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op_e;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_INVALID   = 2'd3
    } t_status_e;

    typedef struct packed {
        logic accept;
        logic div_init;
        logic div_step;
        logic rd_capture;
    } t_dp_cmd;

    typedef struct packed {
        logic pop_read;
        logic div_last;
    } t_dp_status;

endpackage

// ===== sv/partitioned_multi_stack.sv =====
// Top level of the partitioned multi-stack: register port, controller and datapath.
//
// Up to eight LIFO stacks share one 256-word memory split into equal partitions of
// total_entries / stack_count words. Each request is a push or a pop on one stack and
// returns one result with a status code. A push, or any refused or failed request, is
// answered directly from the output register; a pop that returns stored data waits on the
// registered read port of the shared memory. A result waiting in the output register holds
// off the next request until it is taken. Writing either register clears every stack and
// recomputes the partition size in a bit-serial divider: requests are held off until the
// divider has finished.
module partitioned_multi_stack (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [31:0]                      i_s_tdata,  // [31:0] push_data
    input  logic [3:0]                       i_s_tuser,  // [0] opcode, [3:1] stack_index
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [31:0]                      o_m_tdata,  // [31:0] pop_data
    output logic [1:0]                       o_m_tuser,  // [1:0] status
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [psk_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [psk_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [psk_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int CNT_W = psk_pkg::CNT_W;
    localparam int TE_W  = psk_pkg::TE_W;

    logic [psk_pkg::CFG_IDX_W-1:0] w_reg_idx;
    logic                          w_cfg_wr;
    logic [CNT_W-1:0]              r_stack_count;
    logic [TE_W-1:0]               r_total_entries;
    psk_pkg::t_dp_cmd              w_cmd;
    psk_pkg::t_dp_status           w_status;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[psk_pkg::APB_ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_count   <= CNT_W'(1);
            r_total_entries <= TE_W'(psk_pkg::MEM_DEPTH);
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                psk_pkg::REG_STACK_COUNT: begin
                    r_stack_count <= pwdata[CNT_W-1:0];
                end
                psk_pkg::REG_TOTAL_ENTRIES: begin
                    r_total_entries <= pwdata[TE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            psk_pkg::REG_STACK_COUNT: begin
                prdata = psk_pkg::APB_DATA_W'(r_stack_count);
            end
            psk_pkg::REG_TOTAL_ENTRIES: begin
                prdata = psk_pkg::APB_DATA_W'(r_total_entries);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    psk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (w_cfg_wr),
        .i_in_valid  (i_s_tvalid),
        .i_out_ready (i_m_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid)
    );

    psk_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_stack_count   (r_stack_count),
        .i_total_entries (r_total_entries),
        .i_opcode        (i_s_tuser[0]),
        .i_stack_index   (i_s_tuser[3:1]),
        .i_push_data     (i_s_tdata),
        .o_pop_data      (o_m_tdata),
        .o_result_status (o_m_tuser)
    );

`ifndef SYNTH
    a_cfg_blocks_requests: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> !o_s_tready)
        else $error("request taken during partition setup");

    a_capture_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_capture |-> $past(w_cmd.accept))
        else $error("memory read captured without a preceding pop");

    a_no_take_while_stuck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!o_m_tvalid || i_m_tready))
        else $error("request taken while result register is held");
`endif

endmodule

// ===== sv/psk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/psk_ctrl.sv =====
// Controller state machine: request acceptance, partition setup sequencing and result hand-off.
module psk_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    input  psk_pkg::t_dp_status  i_status,
    output psk_pkg::t_dp_cmd     o_cmd,
    output logic                 o_in_ready,
    output logic                 o_out_valid
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DINIT = 4'b0010,
        S_DIV   = 4'b0100,
        S_READ  = 4'b1000
    } t_state_e;

    t_state_e         r_state;
    t_state_e         n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_in_ready;
    psk_pkg::t_dp_cmd w_cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        w_cmd       = '0;
        w_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
        w_cmd.accept = w_in_ready && i_in_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_cmd.accept) begin
                    if (i_status.pop_read) begin
                        n_state = S_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_DINIT: begin
                w_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                w_cmd.rd_capture = 1'b1;
                n_out_valid      = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // restart partition setup on any register write
        if (i_cfg_wr) begin
            n_state = S_DINIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/psk_datapath.sv =====
// Datapath: partition divider, fill counters, address generation, shared memory and result register.
module psk_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  psk_pkg::t_dp_cmd                  i_cmd,
    output psk_pkg::t_dp_status               o_status,
    input  logic [psk_pkg::CNT_W-1:0]         i_stack_count,
    input  logic [psk_pkg::TE_W-1:0]          i_total_entries,
    input  logic                              i_opcode,
    input  logic [psk_pkg::IDX_W-1:0]         i_stack_index,
    input  logic [psk_pkg::DATA_WIDTH-1:0]    i_push_data,
    output logic [psk_pkg::DATA_WIDTH-1:0]    o_pop_data,
    output logic [1:0]                        o_result_status
);

    localparam int CNT_W     = psk_pkg::CNT_W;
    localparam int TE_W      = psk_pkg::TE_W;
    localparam int PSIZE_W   = psk_pkg::PSIZE_W;
    localparam int PROD_W    = psk_pkg::PROD_W;
    localparam int DIV_CNT_W = psk_pkg::DIV_CNT_W;
    localparam int DW        = psk_pkg::DATA_WIDTH;

    logic [CNT_W-1:0]     w_stacks;
    logic [TE_W-1:0]      w_words;

    logic [CNT_W-1:0]     r_rem;
    logic [PSIZE_W-1:0]   r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [PSIZE_W-1:0]   r_psize;
    logic [CNT_W:0]       w_trial;
    logic                 w_ge;
    logic [CNT_W-1:0]     w_rem_next;
    logic [PSIZE_W-1:0]   w_quo_next;
    logic                 w_div_last;

    logic [PSIZE_W-1:0]   r_fill [psk_pkg::MAX_STACKS];
    logic [PSIZE_W-1:0]   w_fill;
    logic                 w_valid_idx;
    logic [PROD_W-1:0]    w_base;
    logic [PROD_W-1:0]    w_push_addr;
    logic [PROD_W-1:0]    w_pop_addr;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_push_in;
    logic                 w_pop_in;

    psk_pkg::t_status_e   w_res_status;
    logic [DW-1:0]        w_res_data;
    logic                 w_wr_en;
    logic                 w_rd_en;
    logic                 w_fill_inc;
    logic                 w_fill_dec;
    logic [DW-1:0]        w_rd_data;

    logic [DW-1:0]        r_out_data;
    psk_pkg::t_status_e   r_out_status;

    assign w_stacks = (i_stack_count > CNT_W'(psk_pkg::MAX_STACKS)) ?
                      CNT_W'(psk_pkg::MAX_STACKS) : i_stack_count;
    assign w_words  = (i_total_entries > TE_W'(psk_pkg::MEM_DEPTH)) ?
                      TE_W'(psk_pkg::MEM_DEPTH) : i_total_entries;

    // restoring divider, one quotient bit a step
    assign w_trial    = {r_rem, r_quo[PSIZE_W-1]};
    assign w_ge       = w_trial >= {1'b0, w_stacks};
    assign w_rem_next = w_ge ? CNT_W'(w_trial - {1'b0, w_stacks}) : w_trial[CNT_W-1:0];
    assign w_quo_next = {r_quo[PSIZE_W-2:0], w_ge};
    assign w_div_last = r_div_cnt == DIV_CNT_W'(PSIZE_W - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
            r_psize   <= PSIZE_W'(psk_pkg::MEM_DEPTH);
        end else if (i_cmd.div_init) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            if (w_div_last) begin
                r_psize <= (w_stacks == '0) ? '0 : w_quo_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= PSIZE_W'(w_words);
        end else if (i_cmd.div_step) begin
            r_rem <= w_rem_next;
            r_quo <= w_quo_next;
        end
    end

    assign w_fill      = r_fill[i_stack_index];
    assign w_valid_idx = CNT_W'(i_stack_index) < w_stacks;
    assign w_base      = PROD_W'(i_stack_index) * PROD_W'(r_psize);
    assign w_push_addr = w_base + PROD_W'(w_fill);
    assign w_pop_addr  = w_base + PROD_W'(w_fill) - PROD_W'(1);
    assign w_full      = w_fill >= r_psize;
    assign w_empty     = w_fill == '0;
    assign w_push_in   = w_push_addr < PROD_W'(psk_pkg::MEM_DEPTH);
    assign w_pop_in    = w_pop_addr < PROD_W'(psk_pkg::MEM_DEPTH);

    always_comb begin
        w_res_status = psk_pkg::ST_OK;
        w_res_data   = '0;
        w_wr_en      = 1'b0;
        w_rd_en      = 1'b0;
        w_fill_inc   = 1'b0;
        w_fill_dec   = 1'b0;
        if (!w_valid_idx) begin
            w_res_status = psk_pkg::ST_INVALID;
            w_res_data   = (i_opcode == psk_pkg::OP_POP) ? '1 : '0;
        end else if (i_opcode == psk_pkg::OP_PUSH) begin
            if (w_full || !w_push_in) begin
                w_res_status = psk_pkg::ST_OVERFLOW;
            end else begin
                w_wr_en    = 1'b1;
                w_fill_inc = 1'b1;
            end
        end else if (w_empty) begin
            w_res_status = psk_pkg::ST_UNDERFLOW;
            w_res_data   = '1;
        end else begin
            w_fill_dec = 1'b1;
            w_rd_en    = w_pop_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < psk_pkg::MAX_STACKS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (i_cmd.div_init) begin
            for (int i = 0; i < psk_pkg::MAX_STACKS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (i_cmd.accept) begin
            if (w_fill_inc) begin
                r_fill[i_stack_index] <= w_fill + PSIZE_W'(1);
            end else if (w_fill_dec) begin
                r_fill[i_stack_index] <= w_fill - PSIZE_W'(1);
            end
        end
    end

    psk_ram #(
        .WIDTH (DW),
        .DEPTH (psk_pkg::MEM_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.accept && w_wr_en),
        .i_wr_addr (w_push_addr[psk_pkg::ADDR_W-1:0]),
        .i_wr_data (i_push_data),
        .i_rd_en   (i_cmd.accept && w_rd_en),
        .i_rd_addr (w_pop_addr[psk_pkg::ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_out_data   <= w_res_data;
            r_out_status <= w_res_status;
        end else if (i_cmd.rd_capture) begin
            r_out_data <= w_rd_data;
        end
    end

    assign o_status.pop_read = w_rd_en;
    assign o_status.div_last = w_div_last;
    assign o_pop_data        = r_out_data;
    assign o_result_status   = r_out_status;

endmodule
